[rtl/qdr_pkg.sv]
`default_nettype none

package qdr_pkg;

    localparam int QDR_CHANNELS = 2;

    localparam logic [9:0] RATE_DIVISOR_RESET = 10'd90;
    localparam int MS_PER_SECOND = 1000;

    // |delta| * 1000 < 2^42, elapsed_ms * rate_divisor < 2^26
    localparam int DVD_W     = 42;
    localparam int DVS_W     = 26;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    localparam logic REG_RATE_DIVISOR = 1'b0;

    localparam logic signed [2:0] STEP_TABLE [16] = '{
        3'sd0,  3'sd1, -3'sd1,  3'sd2, -3'sd1,  3'sd0, -3'sd2,  3'sd1,
        3'sd1, -3'sd2,  3'sd0, -3'sd1,  3'sd2, -3'sd1,  3'sd1,  3'sd0
    };

    typedef struct packed {
        logic [1:0]         pins;
        logic signed [31:0] pos;
        logic signed [31:0] last;
    } entry_t;

endpackage

`default_nettype wire

[rtl/qdr_ram.sv]
`default_nettype none

module qdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/quadrature_decoder_with_rate.sv]
// Multi-channel 4x quadrature decoder with a rate estimate. Per-channel pins, position and
// last polled position live in one small RAM; a flip-flop valid bit per channel makes every
// channel read as zero right after reset, so there is no clearing pass. One item is handled
// at a time. A pin sample, a clear, an unused opcode and a poll with elapsed_ms of zero pass
// from accept to the result register through accept, read-modify-write and output load.
// A poll runs accept, read-modify-write, multiply by 1000, 42 steps of the
// restoring divider by elapsed_ms * rate_divisor, saturate, output load. The next beat is
// accepted as soon as the result is loaded, even while it still waits on m_tready.
`default_nettype none

module quadrature_decoder_with_rate
    import qdr_pkg::*;
#(
    parameter int CHANNELS = QDR_CHANNELS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // channel, pin_a, pin_b, elapsed_ms[15:0], zero pad
    input  wire logic [1:0]  s_tuser,   // operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // out_channel, position[31:0], rate[31:0], zero pad
    output logic      [1:0]  m_tuser,   // rate_valid, divide_error

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SAT  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]          state_reg;
    logic [9:0]          rate_div_reg;
    logic [CHANNELS-1:0] vld_reg;

    logic [1:0]          op_reg;
    logic                ch_reg;
    logic [1:0]          pins_reg;
    logic [15:0]         elapsed_reg;
    logic                in_range_reg;
    logic                rd_vld_reg;

    logic signed [32:0]  delta_reg;
    logic [DVS_W-1:0]    dvs_reg;
    logic [DVD_W-1:0]    quo_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic signed [31:0]  res_pos_reg;
    logic signed [31:0]  res_rate_reg;
    logic                res_valid_reg;
    logic                res_derr_reg;

    logic                m_tvalid_reg;
    logic [71:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic                s_beat;
    logic                in_range;
    logic [AW-1:0]       raddr;
    logic [$bits(entry_t)-1:0] rdata;
    entry_t              entry;
    entry_t              entry_next;
    logic                ram_we;
    logic signed [2:0]   step;
    logic signed [33:0]  sum;
    logic signed [31:0]  pos_sat;
    logic [9:0]          div_eff;
    logic [32:0]         mag;
    logic [DVS_W:0]      trial;
    logic                qbit;
    logic                out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign in_range = int'(s_tdata[0]) < CHANNELS;
    assign raddr    = AW'(s_tdata[0]);
    assign out_free = !m_tvalid_reg || m_tready;

    qdr_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CHANNELS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(ch_reg)),
        .wdata (entry_next),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        entry = rd_vld_reg ? entry_t'(rdata) : '0;
        step  = STEP_TABLE[{pins_reg, entry.pins}];
        sum   = {{2{entry.pos[31]}}, entry.pos} + {{31{step[2]}}, step};
        if (sum > 34'sd2147483647) begin
            pos_sat = 32'sh7fffffff;
        end else if (sum < -34'sd2147483648) begin
            pos_sat = 32'sh80000000;
        end else begin
            pos_sat = sum[31:0];
        end
        entry_next = entry;
        ram_we     = 1'b0;
        if (state_reg == ST_EXEC && in_range_reg) begin
            unique case (op_reg)
                OP_SAMPLE: begin
                    entry_next.pins = pins_reg;
                    entry_next.pos  = pos_sat;
                    ram_we          = 1'b1;
                end
                OP_CLEAR: begin
                    entry_next.pos = '0;
                    ram_we         = 1'b1;
                end
                OP_POLL: begin
                    entry_next.last = entry.pos;
                    ram_we          = 1'b1;
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    assign div_eff = (rate_div_reg == '0) ? 10'd1 : rate_div_reg;
    assign mag     = delta_reg[32] ? 33'(-delta_reg) : 33'(delta_reg);
    assign trial   = {rem_reg, quo_reg[DVD_W-1]};
    assign qbit    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                vld_reg[AW'(ch_reg)] <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (in_range_reg && op_reg == OP_POLL && elapsed_reg != '0) begin
                        state_reg <= ST_MUL;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg       <= s_tuser;
            ch_reg       <= s_tdata[0];
            pins_reg     <= {s_tdata[2], s_tdata[1]};
            elapsed_reg  <= s_tdata[18:3];
            in_range_reg <= in_range;
            rd_vld_reg   <= in_range ? vld_reg[raddr] : 1'b0;
        end
        case (state_reg)
            ST_EXEC: begin
                res_rate_reg  <= '0;
                res_valid_reg <= 1'b0;
                res_derr_reg  <= in_range_reg && op_reg == OP_POLL && elapsed_reg == '0;
                res_pos_reg   <= in_range_reg ? entry_next.pos : '0;
                delta_reg     <= {entry.pos[31], entry.pos} - {entry.last[31], entry.last};
                dvs_reg       <= DVS_W'(elapsed_reg) * DVS_W'(div_eff);
            end
            ST_MUL: begin
                quo_reg <= DVD_W'(mag) * DVD_W'(MS_PER_SECOND);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            ST_DIV: begin
                rem_reg <= qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], qbit};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            ST_SAT: begin
                res_valid_reg <= 1'b1;
                if (!delta_reg[32]) begin
                    res_rate_reg <= (quo_reg > DVD_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                                     : quo_reg[31:0];
                end else begin
                    res_rate_reg <= (quo_reg > DVD_W'(32'h80000000)) ? 32'sh80000000
                                                                     : -quo_reg[31:0];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {7'b0, res_rate_reg, res_pos_reg, ch_reg};
                    m_tuser_reg <= {res_derr_reg, res_valid_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_div_reg <= RATE_DIVISOR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_RATE_DIVISOR) begin
            rate_div_reg <= pwdata[9:0];
        end
    end

    assign prdata = (paddr[2] == REG_RATE_DIVISOR) ? {22'b0, rate_div_reg} : 32'b0;
    assign pready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> state_reg == ST_EXEC)
        else $error("accepted beat did not enter execute");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider running with zero step count");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("rate_valid and divide_error both set");

    a_rate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> m_tdata[64:33] == 32'b0)
        else $error("nonzero rate without rate_valid");

    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result load did not complete");

endmodule

`default_nettype wire

[dv/quadrature_decoder_with_rate_checker.sv]
`timescale 1ns / 1ps

module quadrature_decoder_with_rate_checker
    import qdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // channel, pin_a, pin_b, elapsed_ms[15:0], zero pad
    input  logic [1:0]  s_tuser,   // operation

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // out_channel, position[31:0], rate[31:0], zero pad
    input  logic [1:0]  m_tuser,   // rate_valid, divide_error

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    output int          mismatch_count,
    output int          readings_outstanding
);

    localparam logic [2:0] RATE_DIV_ADDR = {REG_RATE_DIVISOR, 2'b00};

    // position step indexed by {new B, new A, old B, old A}
    localparam int GRAY_STEP [16] = '{
        0, 1, -1, 2, -1, 0, -2, 1, 1, -2, 0, -1, 2, -1, 1, 0
    };

    typedef struct {
        logic               channel;
        logic signed [31:0] position;
        logic signed [31:0] rate;
        logic               rate_valid;
        logic               divide_error;
    } reading_t;

    reading_t           readings [$];
    logic [9:0]         rate_div;
    logic [1:0]         pin_state   [QDR_CHANNELS];
    logic signed [31:0] count       [QDR_CHANNELS];
    logic signed [31:0] polled_at   [QDR_CHANNELS];

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
        if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic reading_t decode_beat(input logic [1:0] op, input logic ch,
                                             input logic pa, input logic pb,
                                             input logic [15:0] elapsed);
        reading_t   rd;
        logic [3:0] code;
        longint     delta;
        longint     scaled;
        longint     divisor;
        rd.channel      = ch;
        rd.rate         = '0;
        rd.rate_valid   = 1'b0;
        rd.divide_error = 1'b0;
        case (op)
            OP_SAMPLE: begin
                code = {pb, pa, pin_state[ch]};
                pin_state[ch] = {pb, pa};
                count[ch] = sat32(longint'(count[ch]) + GRAY_STEP[code]);
            end
            OP_CLEAR: begin
                count[ch] = '0;
            end
            OP_POLL: begin
                delta = longint'(count[ch]) - longint'(polled_at[ch]);
                polled_at[ch] = count[ch];
                if (elapsed == 16'd0) begin
                    rd.divide_error = 1'b1;
                end else begin
                    divisor = (rate_div == 10'd0) ? 64'sd1 : longint'(rate_div);
                    scaled = (delta * MS_PER_SECOND) / longint'(elapsed);
                    scaled = scaled / divisor;
                    rd.rate = sat32(scaled);
                    rd.rate_valid = 1'b1;
                end
            end
            default: ;
        endcase
        rd.position = count[ch];
        return rd;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            readings.delete();
            rate_div = RATE_DIVISOR_RESET;
            for (int k = 0; k < QDR_CHANNELS; k++) begin
                pin_state[k] = '0;
                count[k]     = '0;
                polled_at[k] = '0;
            end
        end else begin
            if (psel && penable && pwrite && pready && paddr == RATE_DIV_ADDR)
                rate_div = pwdata[9:0];
            if (m_tvalid && m_tready) begin
                if (readings.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat, expected none, got channel %0d position %0d",
                             $time, m_tdata[0], $signed(m_tdata[32:1]));
                end else begin
                    want = readings.pop_front();
                    if (m_tdata[0] !== want.channel)
                        note_mismatch("out_channel", want.channel, m_tdata[0]);
                    if ($signed(m_tdata[32:1]) !== want.position)
                        note_mismatch("position", want.position, $signed(m_tdata[32:1]));
                    if ($signed(m_tdata[64:33]) !== want.rate)
                        note_mismatch("rate", want.rate, $signed(m_tdata[64:33]));
                    if (m_tuser[0] !== want.rate_valid)
                        note_mismatch("rate_valid", want.rate_valid, m_tuser[0]);
                    if (m_tuser[1] !== want.divide_error)
                        note_mismatch("divide_error", want.divide_error, m_tuser[1]);
                end
            end
            if (s_tvalid && s_tready)
                readings.push_back(decode_beat(s_tuser, s_tdata[0], s_tdata[1], s_tdata[2],
                                               s_tdata[18:3]));
        end
        readings_outstanding <= readings.size();
    end

endmodule

[dv/quadrature_decoder_with_rate_tb.sv]
`timescale 1ns / 1ps

module quadrature_decoder_with_rate_tb;
    import qdr_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [2:0] RATE_DIV_ADDR = {REG_RATE_DIVISOR, 2'b00};
    localparam int IDLE_LIMIT      = 5000;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int PHASES          = 6;
    // quadrature cycle as {B, A}
    localparam logic [1:0] QUAD_SEQ [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // channel, pin_a, pin_b, elapsed_ms[15:0], zero pad
    logic [1:0]  s_tuser  = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // out_channel, position[31:0], rate[31:0], zero pad
    logic [1:0]  m_tuser;         // rate_valid, divide_error
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int readings_outstanding;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit sender_idles = 1'b1;
    bit sink_stalls  = 1'b1;
    int phase_idx [2] = '{0, 0};
    int spin_dir  [2] = '{1, 1};

    quadrature_decoder_with_rate u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    quadrature_decoder_with_rate_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_tvalid             (s_tvalid),
        .s_tready             (s_tready),
        .s_tdata              (s_tdata),
        .s_tuser              (s_tuser),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .m_tdata              (m_tdata),
        .m_tuser              (m_tuser),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .pready               (pready),
        .mismatch_count       (mismatch_count),
        .readings_outstanding (readings_outstanding)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("quadrature_decoder_with_rate verification failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    always @(posedge aclk) begin
        if (sink_stalls && stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic ch, input logic pa,
                             input logic pb, input logic [15:0] elapsed);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, elapsed, pb, pa, ch};
        do @(posedge aclk); while (!s_tready);
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (readings_outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_divisor(input logic [9:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RATE_DIV_ADDR;
        pwdata  <= {22'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // move the encoder on a channel by +-1 or 2 quadrature states
    task automatic turn_encoder(input logic ch, input int delta);
        logic [1:0] pins;
        phase_idx[ch] = (phase_idx[ch] + delta + 4) % 4;
        pins = QUAD_SEQ[phase_idx[ch]];
        send_beat(OP_SAMPLE, ch, pins[0], pins[1], 16'($urandom));
    endtask

    function automatic logic [15:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 50) return 16'($urandom_range(1, 50));
        if (r < 80) return 16'($urandom_range(51, 2000));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic random_item();
        int         r;
        logic       ch;
        logic [1:0] pins;
        r  = $urandom_range(0, 99);
        ch = 1'($urandom_range(0, 1));
        if (r < 60) begin
            if ($urandom_range(0, 19) == 0) spin_dir[ch] = -spin_dir[ch];
            turn_encoder(ch, spin_dir[ch]);
        end else if (r < 68) begin
            turn_encoder(ch, 2);
        end else if (r < 72) begin
            pins = 2'($urandom_range(0, 3));
            phase_idx[ch] = {pins[1], pins[1] ^ pins[0]};
            send_beat(OP_SAMPLE, ch, pins[0], pins[1], 16'($urandom));
        end else if (r < 86) begin
            send_beat(OP_POLL, ch, 1'($urandom), 1'($urandom), pick_elapsed());
        end else if (r < 93) begin
            send_beat(OP_CLEAR, ch, 1'($urandom), 1'($urandom), 16'($urandom));
        end else begin
            send_beat(OP_UNUSED, ch, 1'($urandom), 1'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [9:0] divisors [PHASES];
        int         hold_at;
        divisors = '{10'd90, 10'd1, 10'd1023, 10'd0, 10'($urandom_range(2, 1022)), 10'd90};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_beat(OP_POLL, 1'b0, 1'b0, 1'b0, 16'd0);
        repeat (8) turn_encoder(1'b0, 1);
        turn_encoder(1'b0, 2);
        send_beat(OP_SAMPLE, 1'b0, QUAD_SEQ[phase_idx[0]][0], QUAD_SEQ[phase_idx[0]][1],
                  16'hFFFF);
        repeat (4) turn_encoder(1'b1, -1);
        turn_encoder(1'b1, 2);
        send_beat(OP_POLL, 1'b0, 1'b1, 1'b1, 16'd1);
        send_beat(OP_POLL, 1'b1, 1'b0, 1'b0, 16'hFFFF);
        send_beat(OP_UNUSED, 1'b1, 1'b1, 1'b1, 16'hFFFF);
        send_beat(OP_CLEAR, 1'b0, 1'b1, 1'b1, 16'h5555);
        send_beat(OP_POLL, 1'b0, 1'b0, 1'b1, 16'd0);
        send_beat(OP_POLL, 1'b1, 1'b1, 1'b0, 16'd1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                write_divisor(divisors[ph]);
            end
            sender_idles = (ph != 2);
            sink_stalls  = (ph != 3);
            hold_at = $urandom_range(20, 110);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == hold_at) drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && readings_outstanding == 0) begin
            $display("quadrature_decoder_with_rate verification clean");
        end else begin
            $display("quadrature_decoder_with_rate verification failed");
        end
        $finish;
    end

endmodule
